/* hdl/pbrt_pkg.sv */
// Shared types and constants for the packet block rule table.
package pbrt_pkg;

  // Number of rule slots and the index width that addresses them.
  localparam int MAX_RULES = 64;
  localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_RULES - 1);

  // Action codes of a request.
  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_CHECK = 1'b1;

  // Direction codes of a rule or packet.
  localparam logic DIR_IN = 1'b0;
  localparam logic DIR_OUT = 1'b1;

  // Protocol code that matches any packet protocol.
  localparam logic [7:0] PROTO_ANY = 8'd0;

  typedef struct packed {
    logic        action;
    logic        block_flag;
    logic        direction;
    logic [7:0]  protocol;
    logic [31:0] rule_address;
    logic [31:0] source_address;
    logic [31:0] dest_address;
  } req_t;

  typedef struct packed {
    logic accept;
    logic table_full;
  } rsp_t;

  // Rule fields kept in the rule memory.
  typedef struct packed {
    logic        direction;
    logic [7:0]  protocol;
    logic [31:0] address;
  } rule_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_issue;
    logic out_free;
  } status_t;

endpackage

/* hdl/pbrt_ctrl.sv */
// Controller state machine that sequences one request through the rule scan.
module pbrt_ctrl import pbrt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  state_t state;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) state <= S_SCAN;
        end
        S_SCAN: begin
          if (status.last_issue) state <= S_DRAIN;
        end
        S_DRAIN: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (status.out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Command decode.
  always_comb begin
    cmd.load   = (state == S_IDLE) && req_valid;
    cmd.scan   = (state == S_SCAN);
    cmd.commit = (state == S_COMMIT) && status.out_free;
  end

  assign req_stall = (state != S_IDLE);

endmodule

/* hdl/pbrt_datapath.sv */
// Datapath: rule memory, valid and block bits, compare stage and result register.
module pbrt_datapath import pbrt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  req_t    req,
  input  cmd_t    cmd,
  output status_t status,
  output logic    rsp_valid,
  input  logic    rsp_stall,
  output rsp_t    rsp
);

  rule_t            rule_mem [MAX_RULES];
  logic             entry_valid [MAX_RULES];
  logic             entry_block [MAX_RULES];

  req_t             cur;
  logic [IDX_W-1:0] cnt;
  rule_t            rd_rule;
  logic             cmp_live;
  logic [IDX_W-1:0] cmp_idx;

  logic             hit_drop;
  logic             found;
  logic [IDX_W-1:0] found_idx;
  logic             have_free;
  logic [IDX_W-1:0] free_idx;

  logic [31:0]      want_addr;
  logic             slot_valid;
  logic             slot_block;
  logic             chk_hit;
  logic             add_hit;
  logic             full_now;
  logic             insert;
  logic             update;

  // Address that a check compares against: source for inbound, destination for outbound.
  assign want_addr = (cur.direction == DIR_OUT) ? cur.dest_address : cur.source_address;

  // Compare the slot read last cycle against the current request.
  always_comb begin
    chk_hit = slot_valid && slot_block && (rd_rule.direction == cur.direction) &&
              ((rd_rule.protocol == PROTO_ANY) || (rd_rule.protocol == cur.protocol)) &&
              (rd_rule.address == want_addr);
    add_hit = slot_valid && (rd_rule.direction == cur.direction) &&
              (rd_rule.protocol == cur.protocol) && (rd_rule.address == cur.rule_address);
  end

  // Decide what the commit does.
  assign full_now = (cur.action == ACT_ADD) && !found && !have_free;
  assign update   = (cur.action == ACT_ADD) && found;
  assign insert   = (cur.action == ACT_ADD) && !found && have_free;

  // Request capture, scan counter, memory read and match flags.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= req;
      cnt <= '0;
    end else if (cmd.scan) begin
      cnt <= cnt + IDX_W'(1);
    end
    if (cmd.scan) begin
      rd_rule    <= rule_mem[cnt];
      slot_valid <= entry_valid[cnt];
      slot_block <= entry_block[cnt];
      cmp_idx    <= cnt;
    end
    if (cmd.load) begin
      hit_drop  <= 1'b0;
      found     <= 1'b0;
      have_free <= 1'b0;
    end else if (cmp_live) begin
      if (chk_hit) hit_drop <= 1'b1;
      if (add_hit && !found) begin
        found     <= 1'b1;
        found_idx <= cmp_idx;
      end
      if (!slot_valid && !have_free) begin
        have_free <= 1'b1;
        free_idx  <= cmp_idx;
      end
    end
  end

  // The compare stage runs in the cycle after the read.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_live <= 1'b0;
    end else begin
      cmp_live <= cmd.scan;
    end
  end

  // Rule memory write on insert.
  always_ff @(posedge clk) begin
    if (cmd.commit && insert) begin
      rule_mem[free_idx] <= '{direction: cur.direction, protocol: cur.protocol,
                              address: cur.rule_address};
    end
  end

  // Valid bits, cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_RULES; i++) entry_valid[i] <= 1'b0;
    end else if (cmd.commit && insert) begin
      entry_valid[free_idx] <= 1'b1;
    end
  end

  // Block bits, written on insert or on update of a matching rule.
  always_ff @(posedge clk) begin
    if (cmd.commit && insert) begin
      entry_block[free_idx] <= cur.block_flag;
    end else if (cmd.commit && update) begin
      entry_block[found_idx] <= cur.block_flag;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.accept     <= (cur.action == ACT_CHECK) ? !hit_drop : 1'b1;
      rsp.table_full <= full_now;
    end
  end

  assign status.last_issue = cmd.scan && (cnt == LAST_IDX);
  assign status.out_free   = !rsp_valid || !rsp_stall;

  // A new result never overwrites one that is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!rsp_valid || !rsp_stall))
    else $error("result overwritten while stalled");

  // A full report means every slot holds a rule.
  a_full_means_all_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && full_now) |-> (entry_valid.and() == 1'b1))
    else $error("table reported full with a free slot");

  // A matched rule always sits in a valid slot.
  a_found_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && found) |-> entry_valid[found_idx])
    else $error("matched rule is not valid");

  // A commit always presents a result in the next cycle.
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp_valid)
    else $error("commit did not present a result");

endmodule

/* hdl/packet_block_rule_table_top.sv */
// Top level of the packet block rule table: controller plus datapath.
//
//   channel | signals                      | carries
//   --------+------------------------------+------------------------------
//   request | req_valid, req_stall, req    | add rule or check packet
//   result  | rsp_valid, rsp_stall, rsp    | accept and table_full flags
//
// Each request runs through the idle, scan, drain and commit states in turn:
// one memory read per rule slot, one compare drain, one commit. A new request
// is not taken until the one before it has been committed.
// Reset clears all valid bits at once, so the table is empty right after it.
// A stalled result holds the commit until the result register frees; a new
// request is taken while an earlier result still waits.
module packet_block_rule_table_top import pbrt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  pbrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Rule storage and compare.
  pbrt_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
